[sv/fifo_uid_pkg.sv]
// Shared constants and types for the task FIFO with ID allocation.
`timescale 1ns / 1ps
`default_nettype none
package fifo_uid_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ID_W      = 31;
  localparam int HND_W     = 32;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_SHIFT = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_EMPTY   = 2'd2;
  localparam logic [1:0] STS_FLUSHED = 2'd3;

  localparam logic signed [31:0] NO_ID = 32'shFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHRD,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

[sv/fifo_with_unique_id_assign.sv]
// Circular task FIFO with unique ID allocation, memory based.
//
//  port group | dir | handshake              | payload
//  in_        | in  | in_valid / in_ready    | in_cmd, in_task_handle, in_task_id
//  out_       | out | out_valid / out_ready  | out_status, out_id, out_handle
//
// Flush, refused commands and pushes with a given ID finish straight from idle.
// Shift passes through state SHRD, as the entry memories have a registered read.
// Push with an assigned ID finishes straight from idle on an empty queue; else
// each candidate ID is checked by a pipelined sweep of the ID memory, one entry
// per cycle, and a clash moves on to the next candidate and restarts the sweep.
// Reset clears head pointer, level, counter and flushed flag; memories are not cleared.
// A result held in the output register does not stop the next item being taken.
`timescale 1ns / 1ps
`default_nettype none
module fifo_with_unique_id_assign
  import fifo_uid_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [1:0]              in_cmd,
  input  wire  [HND_W-1:0]        in_task_handle,
  input  wire  signed [31:0]      in_task_id,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_id,
  output logic [HND_W-1:0]        out_handle
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam int SW = LW + 1;
  localparam logic [LW-1:0] FULL_LVL = LW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  // entry memories
  logic [HND_W-1:0] hnd_mem [DEPTH];
  logic [ID_W-1:0]  id_mem  [DEPTH];
  logic [HND_W-1:0] hnd_rd_r;
  logic [ID_W-1:0]  id_rd_r;

  state_t state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [LW-1:0]   fill_r, fill_nxt;
  logic [ID_W-1:0] ctr_r, ctr_nxt;
  logic            flushed_r, flushed_nxt;
  logic [LW-1:0]   k_r, k_nxt;
  logic [ID_W-1:0] cand_r, cand_nxt;
  logic            cmp_v_r, cmp_v_nxt;
  logic            cmp_last_r, cmp_last_nxt;
  logic [HND_W-1:0] hnd_r, hnd_nxt;

  logic [1:0]         res_sts_r, res_sts_nxt;
  logic signed [31:0] res_id_r, res_id_nxt;
  logic [HND_W-1:0]   res_hnd_r, res_hnd_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_sts_r, out_sts_nxt;
  logic signed [31:0] out_id_r, out_id_nxt;
  logic [HND_W-1:0]   out_hnd_r, out_hnd_nxt;

  logic               fin;
  logic [1:0]         fin_sts;
  logic signed [31:0] fin_id;
  logic [HND_W-1:0]   fin_hnd;

  logic            mem_we;
  logic [AW-1:0]   wr_addr, rd_addr, scan_addr;
  logic [ID_W-1:0] wr_id;
  logic [HND_W-1:0] wr_hnd;
  logic [ID_W-1:0] cand_inc;
  logic            out_free;
  logic [SW-1:0]   tail_sum, scan_sum;

  assign out_free = !out_valid_r || out_ready;
  assign cand_inc = ctr_r + 1'b1;

  // slot arithmetic modulo DEPTH: both terms are below DEPTH (or level = DEPTH
  // never used for a write), so one compare and subtract is enough
  always_comb begin
    tail_sum  = SW'(head_r) + SW'(fill_r);
    scan_sum  = SW'(head_r) + SW'(k_r);
    if (tail_sum >= DEPTH_S) tail_sum = tail_sum - DEPTH_S;
    if (scan_sum >= DEPTH_S) scan_sum = scan_sum - DEPTH_S;
    wr_addr   = tail_sum[AW-1:0];
    scan_addr = scan_sum[AW-1:0];
  end

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    fill_nxt     = fill_r;
    ctr_nxt      = ctr_r;
    flushed_nxt  = flushed_r;
    k_nxt        = k_r;
    cand_nxt     = cand_r;
    cmp_v_nxt    = cmp_v_r;
    cmp_last_nxt = cmp_last_r;
    hnd_nxt      = hnd_r;
    res_sts_nxt  = res_sts_r;
    res_id_nxt   = res_id_r;
    res_hnd_nxt  = res_hnd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_sts_nxt  = out_sts_r;
    out_id_nxt   = out_id_r;
    out_hnd_nxt  = out_hnd_r;
    in_ready     = 1'b0;
    mem_we       = 1'b0;
    wr_id        = in_task_id[ID_W-1:0];
    wr_hnd       = in_task_handle;
    rd_addr      = head_r;
    fin          = 1'b0;
    fin_sts      = STS_DONE;
    fin_id       = NO_ID;
    fin_hnd      = '0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          hnd_nxt = in_task_handle;
          case (in_cmd)
            CMD_PUSH: begin
              if (flushed_r) begin
                fin     = 1'b1;
                fin_sts = STS_FLUSHED;
                fin_id  = in_task_id;
              end else if (fill_r == FULL_LVL) begin
                fin     = 1'b1;
                fin_sts = STS_FULL;
                fin_id  = in_task_id;
              end else if (!in_task_id[31]) begin
                mem_we   = 1'b1;
                fill_nxt = fill_r + 1'b1;
                fin      = 1'b1;
                fin_id   = in_task_id;
              end else if (fill_r == '0) begin
                // nothing to clash with
                mem_we   = 1'b1;
                wr_id    = cand_inc;
                ctr_nxt  = cand_inc;
                fill_nxt = fill_r + 1'b1;
                fin      = 1'b1;
                fin_id   = {1'b0, cand_inc};
              end else begin
                cand_nxt  = cand_inc;
                k_nxt     = '0;
                cmp_v_nxt = 1'b0;
                state_nxt = ST_SCAN;
              end
            end
            CMD_SHIFT: begin
              if (flushed_r) begin
                fin     = 1'b1;
                fin_sts = STS_FLUSHED;
              end else if (fill_r == '0) begin
                fin     = 1'b1;
                fin_sts = STS_EMPTY;
              end else begin
                rd_addr   = head_r;
                head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
                fill_nxt  = fill_r - 1'b1;
                state_nxt = ST_SHRD;
              end
            end
            CMD_FLUSH: begin
              flushed_nxt = 1'b1;
              fin         = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_SHRD: begin
        fin     = 1'b1;
        fin_id  = {1'b0, id_rd_r};
        fin_hnd = hnd_rd_r;
      end
      ST_SCAN: begin
        // read of entry k issued this cycle, compared the next
        rd_addr = scan_addr;
        if (cmp_v_r && id_rd_r == cand_r) begin
          cand_nxt  = cand_r + 1'b1;
          k_nxt     = '0;
          cmp_v_nxt = 1'b0;
        end else if (cmp_v_r && cmp_last_r) begin
          mem_we   = 1'b1;
          wr_id    = cand_r;
          wr_hnd   = hnd_r;
          ctr_nxt  = cand_r;
          fill_nxt = fill_r + 1'b1;
          fin      = 1'b1;
          fin_id   = {1'b0, cand_r};
        end else if (k_r < fill_r) begin
          cmp_v_nxt    = 1'b1;
          cmp_last_nxt = (k_r == fill_r - 1'b1);
          k_nxt        = k_r + 1'b1;
        end else begin
          cmp_v_nxt = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sts_nxt   = res_sts_r;
          out_id_nxt    = res_id_r;
          out_hnd_nxt   = res_hnd_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_sts_nxt   = fin_sts;
        out_id_nxt    = fin_id;
        out_hnd_nxt   = fin_hnd;
        state_nxt     = ST_IDLE;
      end else begin
        res_sts_nxt = fin_sts;
        res_id_nxt  = fin_id;
        res_hnd_nxt = fin_hnd;
        state_nxt   = ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hnd_mem[wr_addr] <= wr_hnd;
      id_mem[wr_addr]  <= wr_id;
    end
    hnd_rd_r <= hnd_mem[rd_addr];
    id_rd_r  <= id_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      ctr_r       <= '0;
      flushed_r   <= 1'b0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      ctr_r       <= ctr_nxt;
      flushed_r   <= flushed_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    cand_r     <= cand_nxt;
    cmp_last_r <= cmp_last_nxt;
    hnd_r      <= hnd_nxt;
    res_sts_r  <= res_sts_nxt;
    res_id_r   <= res_id_nxt;
    res_hnd_r  <= res_hnd_nxt;
    out_sts_r  <= out_sts_nxt;
    out_id_r   <= out_id_nxt;
    out_hnd_r  <= out_hnd_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_sts_r;
  assign out_id     = out_id_r;
  assign out_handle = out_hnd_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_LVL)
    else $error("fill level beyond depth");

  a_flush_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    flushed_r |=> flushed_r)
    else $error("flushed mode left without reset");

  a_scan_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> (fill_r != '0 && !flushed_r && fill_r != FULL_LVL))
    else $error("ID scan on empty, full or flushed queue");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> out_valid_r)
    else $error("result parked while output register empty");

endmodule
`default_nettype wire
